// ----- sv/pccm_pkg.sv -----
package pccm_pkg;

  // Default geometry of the module
  localparam int unsigned CHIP_COLS_DEF = 60;
  localparam int unsigned CHIP_ROWS_DEF = 97;
  localparam int unsigned NUM_CHIPS_DEF = 16;
  localparam int unsigned MOD_COLS_DEF  = 487;
  localparam int unsigned MOD_ROWS_DEF  = 195;

  // Field widths of the query beat
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned PIX_W  = 17;
  localparam int unsigned MCOL_W = 9;
  localparam int unsigned MROW_W = 8;
  localparam int unsigned CIDX_W = 5;
  localparam int unsigned CCOL_W = 6;
  localparam int unsigned CROW_W = 7;

  // Field widths of the result beat (two's complement, all ones when invalid)
  localparam int unsigned OPIX_W  = 18;
  localparam int unsigned OMCOL_W = 10;
  localparam int unsigned OMROW_W = 9;
  localparam int unsigned OCIDX_W = 5;
  localparam int unsigned OCCOL_W = 7;
  localparam int unsigned OCROW_W = 8;

  // Width of a module column computed from chip coordinates before range check
  localparam int unsigned WIDE_MX_W = 12;

  // Form of the given coordinates
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL  = 2'd0,
    FUNC_MODULE = 2'd1,
    FUNC_CHIP   = 2'd2
  } func_e;

endpackage

// ----- sv/pccm_cdiv.sv -----
module pccm_cdiv #(
  parameter int unsigned DIVIDEND_W = 17,
  parameter int unsigned DIVISOR    = 3
) (
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  // Exact floor division by a constant: multiply by the rounded-up reciprocal.
  // The extra clog2(DIVISOR) fraction bits keep the error below one step.
  localparam int unsigned SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned MULT_W = SHIFT + 1;
  localparam int unsigned PROD_W = SHIFT + DIVIDEND_W;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

  logic [MULT_W-1:0] mult;
  logic [PROD_W-1:0] prod;

  assign mult       = MULT_W'(MULT);
  assign prod       = PROD_W'(dividend_i) * PROD_W'(mult);
  assign quotient_o = prod[SHIFT +: DIVIDEND_W];

endmodule

// ----- sv/module_pixel_chip_coord_map.sv -----
// Coordinate translator for a two-row chip-tiled sensor module.
// Throughput: one beat per cycle while out_stall_i is low; five register stages
// (input, row quotient, module position, chip-column quotient and pixel product,
// result) each hold one beat.
// Reset clears only the stage valid flags; the block keeps no other state.
module module_pixel_chip_coord_map import pccm_pkg::*; #(
  parameter int unsigned CHIP_COLS = CHIP_COLS_DEF,
  parameter int unsigned CHIP_ROWS = CHIP_ROWS_DEF,
  parameter int unsigned NUM_CHIPS = NUM_CHIPS_DEF,
  parameter int unsigned MOD_COLS  = MOD_COLS_DEF,
  parameter int unsigned MOD_ROWS  = MOD_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [PIX_W-1:0]   pixel_index_i,
  input  logic [MCOL_W-1:0]  module_col_i,
  input  logic [MROW_W-1:0]  module_row_i,
  input  logic [CIDX_W-1:0]  chip_index_i,
  input  logic [CCOL_W-1:0]  chip_col_i,
  input  logic [CROW_W-1:0]  chip_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OPIX_W-1:0]  out_pixel_o,
  output logic [OMCOL_W-1:0] out_mod_col_o,
  output logic [OMROW_W-1:0] out_mod_row_o,
  output logic [OCIDX_W-1:0] out_chip_o,
  output logic [OCCOL_W-1:0] out_chip_col_o,
  output logic [OCROW_W-1:0] out_chip_row_o
);

  localparam int unsigned PITCH      = CHIP_COLS + 1;
  localparam int unsigned HALF_ROW   = MOD_ROWS / 2;
  localparam int unsigned HALF_CHIPS = NUM_CHIPS / 2;
  localparam int unsigned TOP_CHIPS  = NUM_CHIPS - HALF_CHIPS;
  localparam int unsigned TOP_CY_LIM = MOD_ROWS - 1 - HALF_ROW;
  localparam int unsigned NUM_PIX    = MOD_COLS * MOD_ROWS;

  typedef struct packed {
    func_e             func;
    logic [PIX_W-1:0]  pix;
    logic [MCOL_W-1:0] mcol;
    logic [MROW_W-1:0] mrow;
    logic [CIDX_W-1:0] cidx;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
  } query_t;

  typedef struct packed {
    query_t            qry;
    logic              pix_ok;
    logic [MROW_W-1:0] quo;
  } quo_t;

  typedef struct packed {
    logic              mod_ok;
    logic              chip_given;
    logic [MCOL_W-1:0] mx;
    logic [MROW_W-1:0] my;
    logic [CIDX_W-1:0] cidx;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
  } pos_t;

  typedef struct packed {
    pos_t              pos;
    logic [MCOL_W-1:0] pq;
    logic [OPIX_W-1:0] pixel;
  } mid_t;

  typedef struct packed {
    logic [OPIX_W-1:0]  pixel;
    logic [OMCOL_W-1:0] mod_col;
    logic [OMROW_W-1:0] mod_row;
    logic [OCIDX_W-1:0] chip;
    logic [OCCOL_W-1:0] chip_col;
    logic [OCROW_W-1:0] chip_row;
  } res_t;

  // Stage valid flags and stage advance conditions
  logic in_v_q, quo_v_q, pos_v_q, mid_v_q, out_v_q;
  logic rdy_in, rdy_quo, rdy_pos, rdy_mid, rdy_out;

  query_t in_q;
  quo_t   quo_d, quo_q;
  pos_t   pos_d, pos_q;
  mid_t   mid_d, mid_q;
  res_t   res_d, res_q;

  // A stage takes a beat when it is empty or its beat moves on
  assign rdy_out    = !out_v_q || !out_stall_i;
  assign rdy_mid    = !mid_v_q || rdy_out;
  assign rdy_pos    = !pos_v_q || rdy_mid;
  assign rdy_quo    = !quo_v_q || rdy_pos;
  assign rdy_in     = !in_v_q || rdy_quo;
  assign in_stall_o = !rdy_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      quo_v_q <= 1'b0;
      pos_v_q <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_in)  in_v_q  <= in_valid_i;
      if (rdy_quo) quo_v_q <= in_v_q;
      if (rdy_pos) pos_v_q <= quo_v_q;
      if (rdy_mid) mid_v_q <= pos_v_q;
      if (rdy_out) out_v_q <= mid_v_q;
    end
  end

  // Payload registers advance with their valid flag
  always_ff @(posedge clk_i) begin
    if (rdy_in && in_valid_i) begin
      in_q.func <= func_e'(func_i);
      in_q.pix  <= pixel_index_i;
      in_q.mcol <= module_col_i;
      in_q.mrow <= module_row_i;
      in_q.cidx <= chip_index_i;
      in_q.ccol <= chip_col_i;
      in_q.crow <= chip_row_i;
    end
    if (rdy_quo && in_v_q)  quo_q <= quo_d;
    if (rdy_pos && quo_v_q) pos_q <= pos_d;
    if (rdy_mid && pos_v_q) mid_q <= mid_d;
    if (rdy_out && mid_v_q) res_q <= res_d;
  end

  // Stage 1: split the linear pixel number into a row
  logic [PIX_W-1:0] row_quo;

  pccm_cdiv #(
    .DIVIDEND_W (PIX_W),
    .DIVISOR    (MOD_COLS)
  ) u_row_div (
    .dividend_i (in_q.pix),
    .quotient_o (row_quo)
  );

  always_comb begin
    quo_d.qry    = in_q;
    quo_d.pix_ok = {1'b0, in_q.pix} < (PIX_W + 1)'(NUM_PIX);
    quo_d.quo    = MROW_W'(row_quo);
  end

  // Stage 2: reduce every given form to a module column and row
  logic [PIX_W-1:0]     row_base;
  logic [WIDE_MX_W-1:0] bot_mx, top_mx, chip_mx;
  logic [MROW_W-1:0]    chip_my;
  logic                 chip_bot, chip_rng, chip_half_ok;

  assign row_base = PIX_W'(quo_q.quo) * PIX_W'(MOD_COLS);
  assign chip_bot = {1'b0, quo_q.qry.cidx} < (CIDX_W + 1)'(HALF_CHIPS);
  assign chip_rng = ({1'b0, quo_q.qry.cidx} < (CIDX_W + 1)'(NUM_CHIPS))
                 && ({1'b0, quo_q.qry.ccol} < (CCOL_W + 1)'(CHIP_COLS))
                 && ({1'b0, quo_q.qry.crow} < (CROW_W + 1)'(CHIP_ROWS));
  assign bot_mx = WIDE_MX_W'(PITCH) * WIDE_MX_W'(quo_q.qry.cidx)
                + WIDE_MX_W'(CHIP_COLS - 1) - WIDE_MX_W'(quo_q.qry.ccol);
  assign top_mx = WIDE_MX_W'(PITCH)
                * WIDE_MX_W'(quo_q.qry.cidx - CIDX_W'(HALF_CHIPS))
                + WIDE_MX_W'(quo_q.qry.ccol);

  always_comb begin
    if (chip_bot) begin
      chip_mx      = bot_mx;
      chip_my      = MROW_W'(quo_q.qry.crow);
      chip_half_ok = {1'b0, quo_q.qry.crow} < (CROW_W + 1)'(HALF_ROW);
    end else begin
      chip_mx      = top_mx;
      chip_my      = MROW_W'(MOD_ROWS - 1) - MROW_W'(quo_q.qry.crow);
      chip_half_ok = {1'b0, quo_q.qry.crow} < (CROW_W + 1)'(TOP_CY_LIM);
    end
  end

  always_comb begin
    pos_d.cidx       = quo_q.qry.cidx;
    pos_d.ccol       = quo_q.qry.ccol;
    pos_d.crow       = quo_q.qry.crow;
    pos_d.mod_ok     = 1'b0;
    pos_d.chip_given = 1'b0;
    pos_d.mx         = quo_q.qry.mcol;
    pos_d.my         = quo_q.qry.mrow;
    case (quo_q.qry.func)
      FUNC_PIXEL: begin
        pos_d.mod_ok = quo_q.pix_ok;
        pos_d.mx     = MCOL_W'(quo_q.qry.pix - row_base);
        pos_d.my     = quo_q.quo;
      end
      FUNC_MODULE: begin
        pos_d.mod_ok = ({1'b0, quo_q.qry.mcol} < (MCOL_W + 1)'(MOD_COLS))
                    && ({1'b0, quo_q.qry.mrow} < (MROW_W + 1)'(MOD_ROWS));
      end
      FUNC_CHIP: begin
        pos_d.mod_ok     = chip_rng && chip_half_ok
                        && (chip_mx < WIDE_MX_W'(MOD_COLS));
        pos_d.chip_given = 1'b1;
        pos_d.mx         = MCOL_W'(chip_mx);
        pos_d.my         = chip_my;
      end
      default: begin
        pos_d.mod_ok = 1'b0;
      end
    endcase
  end

  // Stage 3: chip slot of the column, and the linear pixel number
  logic [MCOL_W-1:0] slot_quo;

  pccm_cdiv #(
    .DIVIDEND_W (MCOL_W),
    .DIVISOR    (PITCH)
  ) u_slot_div (
    .dividend_i (pos_q.mx),
    .quotient_o (slot_quo)
  );

  always_comb begin
    mid_d.pos   = pos_q;
    mid_d.pq    = slot_quo;
    mid_d.pixel = OPIX_W'(pos_q.mx) + OPIX_W'(pos_q.my) * OPIX_W'(MOD_COLS);
  end

  // Stage 4: column inside the slot, chip fields and invalid marking
  logic [MCOL_W-1:0] slot_base, slot_col;
  logic [MROW_W-1:0] top_cy, derived_cy;
  logic              bot_half, derived_ok;

  assign slot_base = MCOL_W'(mid_q.pq * MCOL_W'(PITCH));
  assign slot_col  = mid_q.pos.mx - slot_base;
  assign bot_half  = {1'b0, mid_q.pos.my} < (MROW_W + 1)'(HALF_ROW);
  assign top_cy    = MROW_W'(MOD_ROWS - 1) - mid_q.pos.my;
  assign derived_cy = bot_half ? mid_q.pos.my : top_cy;

  always_comb begin
    derived_ok = ({1'b0, mid_q.pos.my} != (MROW_W + 1)'(HALF_ROW))
              && ({1'b0, slot_col} < (MCOL_W + 1)'(CHIP_COLS))
              && ({1'b0, derived_cy} < (MROW_W + 1)'(CHIP_ROWS));
    if (bot_half) begin
      derived_ok = derived_ok && ({1'b0, mid_q.pq} < (MCOL_W + 1)'(HALF_CHIPS));
    end else begin
      derived_ok = derived_ok && ({1'b0, mid_q.pq} < (MCOL_W + 1)'(TOP_CHIPS));
    end
  end

  always_comb begin
    res_d = '1;
    if (mid_q.pos.mod_ok) begin
      res_d.pixel   = mid_q.pixel;
      res_d.mod_col = OMCOL_W'(mid_q.pos.mx);
      res_d.mod_row = OMROW_W'(mid_q.pos.my);
      if (mid_q.pos.chip_given) begin
        res_d.chip     = OCIDX_W'(mid_q.pos.cidx);
        res_d.chip_col = OCCOL_W'(mid_q.pos.ccol);
        res_d.chip_row = OCROW_W'(mid_q.pos.crow);
      end else if (derived_ok) begin
        if (bot_half) begin
          res_d.chip     = OCIDX_W'(mid_q.pq);
          res_d.chip_col = OCCOL_W'(MCOL_W'(CHIP_COLS - 1) - slot_col);
        end else begin
          res_d.chip     = OCIDX_W'(MCOL_W'(HALF_CHIPS) + mid_q.pq);
          res_d.chip_col = OCCOL_W'(slot_col);
        end
        res_d.chip_row = OCROW_W'(derived_cy);
      end
    end
  end

  // Drive the result beat
  assign out_valid_o    = out_v_q;
  assign out_pixel_o    = res_q.pixel;
  assign out_mod_col_o  = res_q.mod_col;
  assign out_mod_row_o  = res_q.mod_row;
  assign out_chip_o     = res_q.chip;
  assign out_chip_col_o = res_q.chip_col;
  assign out_chip_row_o = res_q.chip_row;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench import pccm_pkg::*;;

  // Module geometry, as signed ints for the coordinate arithmetic
  localparam int CHIP_COLS  = int'(CHIP_COLS_DEF);
  localparam int CHIP_ROWS  = int'(CHIP_ROWS_DEF);
  localparam int NUM_CHIPS  = int'(NUM_CHIPS_DEF);
  localparam int MOD_COLS   = int'(MOD_COLS_DEF);
  localparam int MOD_ROWS   = int'(MOD_ROWS_DEF);
  localparam int PITCH      = CHIP_COLS + 1;
  localparam int HALF_ROW   = MOD_ROWS / 2;
  localparam int HALF_CHIPS = NUM_CHIPS / 2;
  localparam int NUM_PIXELS = MOD_COLS * MOD_ROWS;

  // Selector code outside the defined forms
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 19;
  localparam int SETTLE_WAIT  = 12;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 60;

  // All six coordinates of one result beat, all ones when unknown
  typedef struct packed {
    logic signed [OPIX_W-1:0]  pixel;
    logic signed [OMCOL_W-1:0] mod_col;
    logic signed [OMROW_W-1:0] mod_row;
    logic signed [OCIDX_W-1:0] chip;
    logic signed [OCCOL_W-1:0] chip_col;
    logic signed [OCROW_W-1:0] chip_row;
  } coords_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FUNC_W-1:0]  func_i = '0;
  logic [PIX_W-1:0]   pixel_index_i = '0;
  logic [MCOL_W-1:0]  module_col_i = '0;
  logic [MROW_W-1:0]  module_row_i = '0;
  logic [CIDX_W-1:0]  chip_index_i = '0;
  logic [CCOL_W-1:0]  chip_col_i = '0;
  logic [CROW_W-1:0]  chip_row_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OPIX_W-1:0]  out_pixel_o;
  logic [OMCOL_W-1:0] out_mod_col_o;
  logic [OMROW_W-1:0] out_mod_row_o;
  logic [OCIDX_W-1:0] out_chip_o;
  logic [OCCOL_W-1:0] out_chip_col_o;
  logic [OCROW_W-1:0] out_chip_row_o;

  coords_t pending_coords[$];
  int      error_count = 0;
  int      beats_checked = 0;
  int      queries_by_func[4] = '{0, 0, 0, 0};
  bit      steady = 1'b0;

  module_pixel_chip_coord_map dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .pixel_index_i  (pixel_index_i),
    .module_col_i   (module_col_i),
    .module_row_i   (module_row_i),
    .chip_index_i   (chip_index_i),
    .chip_col_i     (chip_col_i),
    .chip_row_i     (chip_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_pixel_o    (out_pixel_o),
    .out_mod_col_o  (out_mod_col_o),
    .out_mod_row_o  (out_mod_row_o),
    .out_chip_o     (out_chip_o),
    .out_chip_col_o (out_chip_col_o),
    .out_chip_row_o (out_chip_row_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Map a module position to all six coordinates
  function automatic coords_t module_to_coords(int mx, int my);
    coords_t c;
    int      r;
    int      cn;
    int      cx;
    int      cy;
    c = '1;
    if (mx >= MOD_COLS || my >= MOD_ROWS) return c;
    c.pixel   = OPIX_W'(mx + my * MOD_COLS);
    c.mod_col = OMCOL_W'(mx);
    c.mod_row = OMROW_W'(my);
    // middle row and gap columns belong to no chip
    if (my == HALF_ROW) return c;
    r = mx % PITCH;
    if (r >= CHIP_COLS) return c;
    if (my < HALF_ROW) begin
      // bottom half: columns mirrored
      cn = mx / PITCH;
      cx = CHIP_COLS - 1 - r;
      cy = my;
      if (cn >= HALF_CHIPS) return c;
    end else begin
      cn = HALF_CHIPS + mx / PITCH;
      cx = r;
      cy = MOD_ROWS - my - 1;
      if (cn >= NUM_CHIPS) return c;
    end
    if (cy >= CHIP_ROWS) return c;
    c.chip     = OCIDX_W'(cn);
    c.chip_col = OCCOL_W'(cx);
    c.chip_row = OCROW_W'(cy);
    return c;
  endfunction

  // Map a chip position back onto the module
  function automatic coords_t chip_to_coords(int cn, int cx, int cy);
    coords_t c;
    int      mx;
    int      my;
    c = '1;
    if (cn >= NUM_CHIPS || cx >= CHIP_COLS || cy >= CHIP_ROWS) return c;
    if (cn < HALF_CHIPS) begin
      mx = PITCH * cn + (CHIP_COLS - 1 - cx);
      my = cy;
      if (my >= HALF_ROW) return c;
    end else begin
      mx = PITCH * (cn - HALF_CHIPS) + cx;
      my = MOD_ROWS - cy - 1;
      if (my <= HALF_ROW) return c;
    end
    if (mx >= MOD_COLS) return c;
    c.pixel    = OPIX_W'(mx + my * MOD_COLS);
    c.mod_col  = OMCOL_W'(mx);
    c.mod_row  = OMROW_W'(my);
    c.chip     = OCIDX_W'(cn);
    c.chip_col = OCCOL_W'(cx);
    c.chip_row = OCROW_W'(cy);
    return c;
  endfunction

  function automatic coords_t predict_coords(
    logic [FUNC_W-1:0] f, logic [PIX_W-1:0] pix, logic [MCOL_W-1:0] mcol,
    logic [MROW_W-1:0] mrow, logic [CIDX_W-1:0] cidx, logic [CCOL_W-1:0] ccol,
    logic [CROW_W-1:0] crow);
    coords_t c;
    int      p;
    c = '1;
    p = int'(pix);
    case (f)
      FUNC_PIXEL: begin
        if (p < NUM_PIXELS) c = module_to_coords(p % MOD_COLS, p / MOD_COLS);
      end
      FUNC_MODULE: c = module_to_coords(int'(mcol), int'(mrow));
      FUNC_CHIP:   c = chip_to_coords(int'(cidx), int'(ccol), int'(crow));
      default:     c = '1;
    endcase
    return c;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Drive one query beat and hold it until accepted
  task automatic send_query(
    logic [FUNC_W-1:0] f, logic [PIX_W-1:0] pix, logic [MCOL_W-1:0] mcol,
    logic [MROW_W-1:0] mrow, logic [CIDX_W-1:0] cidx, logic [CCOL_W-1:0] ccol,
    logic [CROW_W-1:0] crow);
    // idle the input at random
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    pixel_index_i <= pix;
    module_col_i  <= mcol;
    module_row_i  <= mrow;
    chip_index_i  <= cidx;
    chip_col_i    <= ccol;
    chip_row_i    <= crow;
    do @(posedge clk_i); while (in_stall_o);
    pending_coords.push_back(predict_coords(f, pix, mcol, mrow, cidx, ccol, crow));
    queries_by_func[f]++;
  endtask

  task automatic send_pixel(int pix);
    send_query(FUNC_PIXEL, PIX_W'(pix), '0, '0, '0, '0, '0);
  endtask

  task automatic send_module(int mcol, int mrow);
    send_query(FUNC_MODULE, '0, MCOL_W'(mcol), MROW_W'(mrow), '0, '0, '0);
  endtask

  task automatic send_chip(int cidx, int ccol, int crow);
    send_query(FUNC_CHIP, '0, '0, '0, CIDX_W'(cidx), CCOL_W'(ccol), CROW_W'(crow));
  endtask

  // Drop valid and hold off until every expected beat has come back
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_coords.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_coords.size() != 0)
      report_error($sformatf("%0d result beats never arrived", pending_coords.size()));
  endtask

  // Random query, mostly in range, with a bias toward gaps and the middle row
  task automatic send_random_query();
    logic [FUNC_W-1:0] f;
    logic [PIX_W-1:0]  pix;
    logic [MCOL_W-1:0] mcol;
    logic [MROW_W-1:0] mrow;
    logic [CIDX_W-1:0] cidx;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
    int                pick;
    pick = $urandom_range(99);
    f    = (pick < 4) ? FUNC_UNUSED : (pick < 36) ? FUNC_PIXEL :
           (pick < 68) ? FUNC_MODULE : FUNC_CHIP;
    pix  = PIX_W'($urandom());
    mcol = MCOL_W'($urandom());
    mrow = MROW_W'($urandom());
    cidx = CIDX_W'($urandom());
    ccol = CCOL_W'($urandom());
    crow = CROW_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 85) begin
      pix  = PIX_W'($urandom_range(NUM_PIXELS - 1));
      mcol = MCOL_W'($urandom_range(MOD_COLS - 1));
      mrow = MROW_W'($urandom_range(MOD_ROWS - 1));
      cidx = CIDX_W'($urandom_range(NUM_CHIPS - 1));
      ccol = CCOL_W'($urandom_range(CHIP_COLS - 1));
      crow = CROW_W'($urandom_range(CHIP_ROWS - 1));
    end
    // steer some queries onto gap columns and the middle row
    pick = $urandom_range(99);
    if (pick < 10) begin
      mcol = MCOL_W'($urandom_range(HALF_CHIPS - 1) * PITCH + CHIP_COLS);
    end else if (pick < 20) begin
      mrow = MROW_W'(HALF_ROW);
      pix  = PIX_W'(HALF_ROW * MOD_COLS + $urandom_range(MOD_COLS - 1));
    end
    send_query(f, pix, mcol, mrow, cidx, ccol, crow);
  endtask

  task automatic test_directed_cases();
    // pixel number extremes
    send_pixel(0);
    send_pixel(NUM_PIXELS - 1);
    send_pixel(NUM_PIXELS);
    send_pixel((1 << PIX_W) - 1);
    send_pixel(HALF_ROW * MOD_COLS + 5);
    // module corners, gap column, middle row, out of range
    send_module(0, 0);
    send_module(MOD_COLS - 1, MOD_ROWS - 1);
    send_module(CHIP_COLS, 3);
    send_module(CHIP_COLS - 1, HALF_ROW - 1);
    send_module(PITCH, HALF_ROW + 1);
    send_module(10, HALF_ROW);
    send_module(MOD_COLS, 0);
    send_module((1 << MCOL_W) - 1, (1 << MROW_W) - 1);
    send_module(0, MOD_ROWS);
    // chip corners in both halves and out of range
    send_chip(0, 0, 0);
    send_chip(HALF_CHIPS - 1, CHIP_COLS - 1, CHIP_ROWS - 1);
    send_chip(HALF_CHIPS, 0, CHIP_ROWS - 1);
    send_chip(NUM_CHIPS - 1, CHIP_COLS - 1, 0);
    send_chip(NUM_CHIPS, 0, 0);
    send_chip((1 << CIDX_W) - 1, (1 << CCOL_W) - 1, (1 << CROW_W) - 1);
    send_chip(3, CHIP_COLS, 5);
    send_chip(12, 7, CHIP_ROWS);
    // unused selector with fields all ones and all zeros
    send_query(FUNC_UNUSED, '1, '1, '1, '1, '1, '1);
    send_query(FUNC_UNUSED, '0, '0, '0, '0, '0, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      send_random_query();
      // pause the sender until the pipeline empties
      if (i == count / 2) wait_for_results();
    end
  endtask

  task automatic test_steady_stream(int count);
    steady = 1'b1;
    for (int i = 0; i < count; i++) send_random_query();
    steady = 1'b0;
  endtask

  // Stall the output at random, except during steady stretches
  always @(posedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    coords_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_coords.size() == 0) begin
        report_error("result beat with no query outstanding");
      end else begin
        want = pending_coords.pop_front();
        beats_checked++;
        if (out_pixel_o !== want.pixel)
          report_error($sformatf("pixel got %0d want %0d",
                                 $signed(out_pixel_o), want.pixel));
        if (out_mod_col_o !== want.mod_col)
          report_error($sformatf("mod_col got %0d want %0d",
                                 $signed(out_mod_col_o), want.mod_col));
        if (out_mod_row_o !== want.mod_row)
          report_error($sformatf("mod_row got %0d want %0d",
                                 $signed(out_mod_row_o), want.mod_row));
        if (out_chip_o !== want.chip)
          report_error($sformatf("chip got %0d want %0d",
                                 $signed(out_chip_o), want.chip));
        if (out_chip_col_o !== want.chip_col)
          report_error($sformatf("chip_col got %0d want %0d",
                                 $signed(out_chip_col_o), want.chip_col));
        if (out_chip_row_o !== want.chip_row)
          report_error($sformatf("chip_row got %0d want %0d",
                                 $signed(out_chip_row_o), want.chip_row));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(1100);
    test_steady_stream(400);
    wait_for_results();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    $display("Checked %0d result beats against the coordinate predictor", beats_checked);
    $display("Queries: %0d pixel, %0d module, %0d chip, %0d unused selector",
             queries_by_func[FUNC_PIXEL], queries_by_func[FUNC_MODULE],
             queries_by_func[FUNC_CHIP], queries_by_func[FUNC_UNUSED]);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("Timeout with %0d result beats outstanding", pending_coords.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
